// ----- rtl/dvi_pkg.sv -----
// dvi_pkg: shared types and constants of the delta varint id codec
`default_nettype none

package dvi_pkg;

  // input item kinds, carried on s_axis_tuser
  typedef enum logic [1:0] {
    OP_ENCODE  = 2'd0,
    OP_DECODE  = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ENC  = 2'd1,
    ST_ID   = 2'd2
  } state_e;

  localparam int unsigned IdW       = 64;
  localparam int unsigned CodeW     = 8;
  localparam int unsigned GroupBits = 7;
  localparam int unsigned ShiftW    = 7;

  localparam logic [ShiftW-1:0] ShiftStep = 7'd7;
  localparam logic [ShiftW-1:0] ShiftSat  = 7'd70;

  // commands from the controller to the datapath
  typedef struct packed {
    logic enc_load;   // take an encode item: delta and accept flag
    logic enc_next;   // drop the group just sent
    logic dec_load;   // take a decode item
    logic restart;    // clear both running ids
    logic show_id;    // result channel shows the decoded id
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic enc_acc;    // pending encode was accepted
    logic enc_more;   // more groups follow the current one
    logic dec_term;   // incoming code byte ends an id
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/delta_varint_id_codec.sv -----
// delta_varint_id_codec: top level of the delta varint id encoder and decoder
//
//  channel  | dir | tdata                          | tuser                      | tlast
//  s_axis   | in  | [63:0] id_in, [71:64] code_in  | [1:0] op                   | -
//  m_axis   | out | [7:0] code_out, [71:8] id_out  | accepted, byte_valid, id_v | last_of_run
//
// one item at a time: s_axis_tready is high only while no result is pending
// encode: the item is taken and its delta formed, then one result per
// code byte (1 to 10); a rejected id gives a single result
// decode: continuation bytes give no result; a terminating byte adds one result
// restart and unused kinds give no result; reset clears both running ids
// results hold on m_axis while m_axis_tready is low
`default_nettype none

module delta_varint_id_codec (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // id_in [63:0], code_in [71:64]
  input  wire logic [1:0]  s_axis_tuser,   // op [1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // code_out [7:0], id_out [71:8]
  output logic [2:0]       m_axis_tuser,   // accepted [0], byte_valid [1], id_valid [2]
  output logic             m_axis_tlast    // last_of_run
);

  dvi_pkg::cmd_t cmd;
  dvi_pkg::sts_t sts;
  logic          accepted;
  logic          byte_valid;
  logic [7:0]    code_out;
  logic          id_valid;
  logic [63:0]   id_out;

  // controller
  dvi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  dvi_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .id_in_i       (s_axis_tdata[63:0]),
    .code_in_i     (s_axis_tdata[71:64]),
    .accepted_o    (accepted),
    .byte_valid_o  (byte_valid),
    .code_out_o    (code_out),
    .last_of_run_o (m_axis_tlast),
    .id_valid_o    (id_valid),
    .id_out_o      (id_out)
  );

  // pack result fields
  assign m_axis_tdata = {id_out, code_out};
  assign m_axis_tuser = {id_valid, byte_valid, accepted};

  // no item is taken while a result is pending
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result is pending");

  // a code byte is last exactly when its continuation bit is clear
  a_byte_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tlast == !m_axis_tdata[7]))
    else $error("code byte continuation bit disagrees with tlast");

  // a decoded id stands alone and ends its run
  a_id_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |->
      m_axis_tlast && !m_axis_tuser[1] && !m_axis_tuser[0])
    else $error("decoded id result carries encode flags");

  // a continuation byte gives no result
  a_cont_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == dvi_pkg::OP_DECODE) &&
      s_axis_tdata[71] |=> s_axis_tready)
    else $error("continuation byte produced a result");

endmodule

`default_nettype wire

// ----- rtl/dvi_ctrl.sv -----
// dvi_ctrl: handshake controller of the delta varint id codec
`default_nettype none

module dvi_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [1:0]    in_op_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire dvi_pkg::sts_t sts_i,
  output dvi_pkg::cmd_t      cmd_o
);

  dvi_pkg::state_e state_q, state_d;
  dvi_pkg::op_e    op;

  assign op = dvi_pkg::op_e'(in_op_i);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dvi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      dvi_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (op)
            dvi_pkg::OP_ENCODE: begin
              cmd_o.enc_load = 1'b1;
              state_d        = dvi_pkg::ST_ENC;
            end
            dvi_pkg::OP_DECODE: begin
              cmd_o.dec_load = 1'b1;
              if (sts_i.dec_term) begin
                state_d = dvi_pkg::ST_ID;
              end
            end
            dvi_pkg::OP_RESTART: begin
              cmd_o.restart = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      dvi_pkg::ST_ENC: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.enc_acc && sts_i.enc_more) begin
            cmd_o.enc_next = 1'b1;
          end else begin
            state_d = dvi_pkg::ST_IDLE;
          end
        end
      end
      dvi_pkg::ST_ID: begin
        out_valid_o   = 1'b1;
        cmd_o.show_id = 1'b1;
        if (out_ready_i) begin
          state_d = dvi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dvi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/dvi_datapath.sv -----
// dvi_datapath: running ids, delta register and group shifter of the codec
`default_nettype none

module dvi_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dvi_pkg::cmd_t               cmd_i,
  output dvi_pkg::sts_t                    sts_o,
  input  wire logic [dvi_pkg::IdW-1:0]     id_in_i,
  input  wire logic [dvi_pkg::CodeW-1:0]   code_in_i,
  output logic                             accepted_o,
  output logic                             byte_valid_o,
  output logic [dvi_pkg::CodeW-1:0]        code_out_o,
  output logic                             last_of_run_o,
  output logic                             id_valid_o,
  output logic [dvi_pkg::IdW-1:0]          id_out_o
);

  localparam int unsigned IdW = dvi_pkg::IdW;
  localparam int unsigned GB  = dvi_pkg::GroupBits;

  logic [IdW-1:0]            enc_last_q, enc_last_d;
  logic [IdW-1:0]            delta_q;
  logic                      acc_q;
  logic [IdW-1:0]            dec_last_q, dec_last_d;
  logic [IdW-1:0]            accum_q, accum_d;
  logic [dvi_pkg::ShiftW-1:0] shift_q, shift_d;
  logic [IdW-1:0]            id_q;
  logic [IdW:0]              diff;
  logic [IdW-1:0]            merged;
  logic [IdW-1:0]            rebuilt;
  logic                      more;

  // id - last - 1 in one adder; carry out says id is above last
  assign diff = {1'b0, id_in_i} + {1'b0, ~enc_last_q};

  // merge the incoming group, dropped once the position passes the word
  always_comb begin
    if (shift_q[dvi_pkg::ShiftW-1]) begin
      merged = accum_q;
    end else begin
      merged = accum_q | ({{(IdW-GB){1'b0}}, code_in_i[GB-1:0]} << shift_q[5:0]);
    end
  end

  assign rebuilt = dec_last_q + merged + {{(IdW-1){1'b0}}, 1'b1};
  assign more    = |delta_q[IdW-1:GB];

  assign sts_o.enc_acc  = acc_q;
  assign sts_o.enc_more = more;
  assign sts_o.dec_term = ~code_in_i[dvi_pkg::CodeW-1];

  // next values of the running state
  always_comb begin
    enc_last_d = enc_last_q;
    dec_last_d = dec_last_q;
    accum_d    = accum_q;
    shift_d    = shift_q;
    if (cmd_i.restart) begin
      enc_last_d = '0;
      dec_last_d = '0;
      accum_d    = '0;
      shift_d    = '0;
    end
    if (cmd_i.enc_load && diff[IdW]) begin
      enc_last_d = id_in_i;
    end
    if (cmd_i.dec_load) begin
      if (sts_o.dec_term) begin
        dec_last_d = rebuilt;
        accum_d    = '0;
        shift_d    = '0;
      end else begin
        accum_d = merged;
        shift_d = shift_q[dvi_pkg::ShiftW-1] ? dvi_pkg::ShiftSat
                                             : shift_q + dvi_pkg::ShiftStep;
      end
    end
  end

  // running state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_last_q <= '0;
      dec_last_q <= '0;
      accum_q    <= '0;
      shift_q    <= '0;
    end else begin
      enc_last_q <= enc_last_d;
      dec_last_q <= dec_last_d;
      accum_q    <= accum_d;
      shift_q    <= shift_d;
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.enc_load) begin
      delta_q <= diff[IdW-1:0];
      acc_q   <= diff[IdW];
    end else if (cmd_i.enc_next) begin
      delta_q <= delta_q >> GB;
    end
    if (cmd_i.dec_load && sts_o.dec_term) begin
      id_q <= rebuilt;
    end
  end

  // result fields
  always_comb begin
    if (cmd_i.show_id) begin
      accepted_o    = 1'b0;
      byte_valid_o  = 1'b0;
      code_out_o    = '0;
      last_of_run_o = 1'b1;
      id_valid_o    = 1'b1;
      id_out_o      = id_q;
    end else begin
      accepted_o    = acc_q;
      byte_valid_o  = acc_q;
      code_out_o    = acc_q ? {more, delta_q[GB-1:0]} : '0;
      last_of_run_o = ~(acc_q & more);
      id_valid_o    = 1'b0;
      id_out_o      = '0;
    end
  end

endmodule

`default_nettype wire

// ----- test/delta_varint_id_codec_tb.sv -----
// delta_varint_id_codec_tb: self-checking testbench of the delta varint id codec

module delta_varint_id_codec_tb;

  // unused item kind, must be ignored by the block
  localparam logic [1:0] OpUnused = 2'd3;

  localparam int unsigned ResetCycles = 9;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned PhaseItems  = 100;
  localparam int unsigned CycleLimit  = 200000;

  // one result item of the block
  typedef struct packed {
    logic        accepted;
    logic        byte_valid;
    logic [7:0]  code_out;
    logic        last_of_run;
    logic        id_valid;
    logic [63:0] id_out;
  } codec_result_t;

  // running ids of the codec and the results they imply
  class codec_scoreboard;
    logic [63:0]                dec_accum;
    logic [63:0]                enc_last_id;
    logic [63:0]                dec_last_id;
    logic [dvi_pkg::ShiftW-1:0] dec_shift;
    codec_result_t              pending_results[$];
    int unsigned                errors;
    int unsigned                checked;

    function new();
      clear_ids();
      errors  = 0;
      checked = 0;
    endfunction

    function void clear_ids();
      enc_last_id = '0;
      dec_last_id = '0;
      dec_accum   = '0;
      dec_shift   = '0;
    endfunction

    function void push_result(logic acc, logic bv, logic [7:0] code, logic last,
                              logic iv, logic [63:0] id);
      codec_result_t r;
      r.accepted    = acc;
      r.byte_valid  = bv;
      r.code_out    = code;
      r.last_of_run = last;
      r.id_valid    = iv;
      r.id_out      = id;
      pending_results.push_back(r);
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // work out the results of one accepted input item
    function void note_item(logic [1:0] op, logic [63:0] id, logic [7:0] code);
      logic [63:0] delta;
      logic [63:0] rebuilt;
      case (op)
        dvi_pkg::OP_ENCODE: begin
          if (id <= enc_last_id) begin
            push_result(1'b0, 1'b0, 8'h00, 1'b1, 1'b0, '0);
          end else begin
            delta = id - enc_last_id - 64'd1;
            // every group but the last carries the continuation bit
            while (delta >= 64'd128) begin
              push_result(1'b1, 1'b1, {1'b1, delta[6:0]}, 1'b0, 1'b0, '0);
              delta = delta >> dvi_pkg::GroupBits;
            end
            push_result(1'b1, 1'b1, delta[7:0], 1'b1, 1'b0, '0);
            enc_last_id = id;
          end
        end
        dvi_pkg::OP_DECODE: begin
          // groups from bit 64 up are dropped
          if (dec_shift < 7'd64) dec_accum = dec_accum | ({57'b0, code[6:0]} << dec_shift);
          if (!code[7]) begin
            rebuilt     = dec_last_id + dec_accum + 64'd1;
            dec_last_id = rebuilt;
            dec_accum   = '0;
            dec_shift   = '0;
            push_result(1'b0, 1'b0, 8'h00, 1'b1, 1'b1, rebuilt);
          end else if (dec_shift < 7'd64) begin
            dec_shift = dec_shift + dvi_pkg::ShiftStep;
          end else begin
            dec_shift = dvi_pkg::ShiftSat;
          end
        end
        dvi_pkg::OP_RESTART: clear_ids();
        default: ;
      endcase
    endfunction

    // one result item as text
    function string show(codec_result_t r);
      return $sformatf("acc=%b bv=%b code=%h last=%b iv=%b id=%h", r.accepted,
                       r.byte_valid, r.code_out, r.last_of_run, r.id_valid, r.id_out);
    endfunction

    task report(string what, codec_result_t got, codec_result_t want);
      errors++;
      $display("mismatch (%s): got %s, want %s", what, show(got), show(want));
    endtask

    // compare one accepted result item with the oldest expectation
    task check_item(codec_result_t got);
      codec_result_t want;
      checked++;
      if (pending_results.size() == 0) begin
        report("unexpected item", got, '0);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) report("field differs", got, want);
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // id_in [63:0], code_in [71:64]
  logic [1:0]  s_axis_tuser = '0;   // op [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // code_out [7:0], id_out [71:8]
  logic [2:0]  m_axis_tuser;        // accepted [0], byte_valid [1], id_valid [2]
  logic        m_axis_tlast;

  codec_scoreboard sb;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  bit              hold_req = 1'b0;
  int unsigned     items_sent = 0;
  int unsigned     cycle_count = 0;

  delta_varint_id_codec u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    codec_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.accepted    = m_axis_tuser[0];
      got.byte_valid  = m_axis_tuser[1];
      got.code_out    = m_axis_tdata[7:0];
      got.last_of_run = m_axis_tlast;
      got.id_valid    = m_axis_tuser[2];
      got.id_out      = m_axis_tdata[71:8];
      sb.check_item(got);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // deltas mostly short, sometimes up to the full width
  function automatic logic [63:0] rand_delta();
    int unsigned nb;
    logic [63:0] r;
    nb = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 21) : $urandom_range(0, 64);
    r  = rand64();
    if (nb == 0) return '0;
    return r >> (64 - nb);
  endfunction

  // offer one input item, with random idle cycles ahead of it
  task automatic send_item(input logic [1:0] op, input logic [63:0] id,
                           input logic [7:0] code);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {code, id};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, id, code);
    items_sent++;
  endtask

  task automatic send_code(input logic [7:0] code);
    send_item(dvi_pkg::OP_DECODE, rand64(), code);
  endtask

  // code bytes of one delta, optionally padded out past the minimal length
  task automatic send_varint(input logic [63:0] delta, input bit overlong);
    logic [63:0] d;
    int unsigned pad;
    d = delta;
    while (d >= 64'd128) begin
      send_code({1'b1, d[6:0]});
      d = d >> dvi_pkg::GroupBits;
    end
    if (overlong) begin
      pad = $urandom_range(1, 6);
      send_code({1'b1, d[6:0]});
      repeat (pad - 1) send_code({1'b1, 7'($urandom())});
      send_code({1'b0, 7'($urandom())});
    end else begin
      send_code({1'b0, d[6:0]});
    end
  endtask

  // random mix, mostly well-formed encodes and code sequences
  task automatic random_items(input int unsigned count);
    int unsigned start;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_item(dvi_pkg::OP_ENCODE, sb.enc_last_id + 64'd1 + rand_delta(),
                  8'($urandom()));
      end else if (pick < 55) begin
        send_item(dvi_pkg::OP_ENCODE, rand64() & sb.enc_last_id, 8'($urandom()));
      end else if (pick < 85) begin
        send_varint(rand_delta(), $urandom_range(0, 9) == 0);
      end else if (pick < 92) begin
        send_code(8'($urandom()));
      end else if (pick < 96) begin
        send_item(dvi_pkg::OP_RESTART, rand64(), 8'($urandom()));
      end else begin
        send_item(OpUnused, rand64(), 8'($urandom()));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // encoder edges: id zero, one-byte extremes, equal and lower ids, ten bytes
    send_item(dvi_pkg::OP_ENCODE, 64'd0, 8'h00);
    send_item(dvi_pkg::OP_ENCODE, 64'd1, 8'hff);
    send_item(dvi_pkg::OP_ENCODE, 64'd129, 8'h00);
    send_item(dvi_pkg::OP_ENCODE, 64'd258, 8'h00);
    send_item(dvi_pkg::OP_ENCODE, 64'd258, 8'h00);
    send_item(dvi_pkg::OP_ENCODE, 64'd5, 8'h00);
    send_item(dvi_pkg::OP_ENCODE, '1, 8'h00);
    send_item(dvi_pkg::OP_RESTART, '0, 8'h00);
    send_item(dvi_pkg::OP_ENCODE, '1, 8'hff);
    send_item(OpUnused, '1, 8'hff);

    // decoder edges: one and two byte codes, restart mid-id
    send_code(8'h00);
    send_code(8'h7f);
    send_code(8'h80);
    send_code(8'h01);
    send_code(8'hff);
    send_code(8'hff);
    send_item(dvi_pkg::OP_RESTART, '1, 8'hff);
    send_code(8'h00);

    // overlong code: top group keeps one bit, shift saturates, id wraps
    repeat (11) send_code(8'hff);
    send_code(8'h7f);

    // idling mixes; the receiver stall mix opens with a long hold-off
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; hold_req = 1'b1; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      random_items(PhaseItems);
    end
    s_axis_tvalid <= 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d input items (encode, decode, restart, unused kind)", items_sent);
    $display("checked %0d result items over four idling mixes and one long hold-off",
             sb.checked);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dvi_pkg.sv
rtl/dvi_ctrl.sv
rtl/dvi_datapath.sv
rtl/delta_varint_id_codec.sv
test/delta_varint_id_codec_tb.sv
